@@ rtl/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SCDE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define SCDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/scde_pkg.sv @@
// ----------------------------------------------------------------------------
// scde_pkg
// types, codes and defaults for the screen cell diff encoder
// ----------------------------------------------------------------------------
package scde_pkg;

   localparam int CELL_COUNT_DEF         = 2048;
   localparam int RECORDS_PER_PACKET_DEF = 16;

   localparam int IDX_W  = 17;   // row * columns + column, compared against up to 65536
   localparam int PEND_W = 6;
   localparam int CSR_W  = 16;

   localparam logic [1:0] CSR_SHARE_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_SCAN_INTERVAL  = 2'd1;
   localparam logic [1:0] CSR_SCREEN_COLUMNS = 2'd2;

   localparam logic        SHARE_ENABLE_RST  = 1'b1;
   localparam logic [15:0] SCAN_INTERVAL_RST = 16'd16;
   localparam logic [7:0]  SCREEN_COLS_RST   = 8'd80;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_END    = 1'b1;

   typedef enum logic [1:0] {
      CMD_SCAN_START = 2'd0,
      CMD_CELL       = 2'd1,
      CMD_SCAN_END   = 2'd2,
      CMD_RESYNC     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DECIDE,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] now_ms;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  chr;
   } req_type;

endpackage

@@ rtl/screen_cell_diff_encoder.sv @@
// ----------------------------------------------------------------------------
// screen_cell_diff_encoder
// terminal screen change encoder with an on-chip character snapshot
// ----------------------------------------------------------------------------
// Every request (scan start, cell, scan end, resync) goes through accept,
// snapshot memory read, and decide and write back; the request port is ready
// again in the cycle after the decide step unless a clearing pass follows.
// The steps are set by the read-modify-write through the single snapshot
// memory and its registered read port. A decide step that produces a result
// holds while the result register is still full and not being taken. A scan
// start that opens a scan on an invalid snapshot is followed by a clearing
// pass over all CELL_COUNT entries, one entry per cycle, during which no
// request is accepted; configuration writes are taken at any time. The
// snapshot needs no pass after reset: no scan can open before such a clear.
module screen_cell_diff_encoder
   import scde_pkg::*;
#(
   parameter int CELL_COUNT         = CELL_COUNT_DEF,
   parameter int RECORDS_PER_PACKET = RECORDS_PER_PACKET_DEF
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [31:0]       req_now_ms,
   input  logic [7:0]        req_cell_row,
   input  logic [7:0]        req_cell_col,
   input  logic [7:0]        req_cell_char,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_out_row,
   output logic [7:0]        rsp_out_col,
   output logic [7:0]        rsp_out_char,
   output logic [PEND_W-1:0] rsp_packet_records,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // configuration registers
   logic        share_en_ff;
   logic [15:0] interval_ff;
   logic [7:0]  cols_ff;

   // control state
   state_type         state_ff, state_in;
   logic              scan_active_ff, scan_active_in;
   logic              snap_valid_ff, snap_valid_in;
   logic [31:0]       next_scan_ff, next_scan_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   // captured request and its snapshot index
   req_type          req_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // snapshot memory
   logic [7:0]    snapshot_mem [CELL_COUNT];
   logic [7:0]    rd_data_ff;
   logic          mem_rd_en;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [7:0]        rsp_row_ff, rsp_col_ff, rsp_char_ff;
   logic [PEND_W-1:0] rsp_recs_ff;

   // decide step
   logic              accept;
   logic              have_res;
   logic              res_kind;
   logic [7:0]        res_row, res_col, res_char;
   logic [PEND_W-1:0] res_recs;
   logic              rec_write;
   logic              start_clear;
   logic              stall;
   logic              commit;
   logic              clr_last;

   assign accept   = req_valid && req_ready;
   assign clr_last = (clr_addr_ff == AW'(CELL_COUNT - 1));

   // configuration port, always ready; indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         share_en_ff <= SHARE_ENABLE_RST;
         interval_ff <= SCAN_INTERVAL_RST;
         cols_ff     <= SCREEN_COLS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHARE_ENABLE:   share_en_ff <= csr_wdata[0];
            CSR_SCAN_INTERVAL:  interval_ff <= csr_wdata;
            CSR_SCREEN_COLUMNS: cols_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // snapshot index, one 8x8 multiply and an add, registered at accept
   assign idx_in = IDX_W'(16'(req_cell_row) * 16'(cols_ff)) + IDX_W'(req_cell_col);

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.cmd    <= cmd_type'(req_cmd);
         req_ff.now_ms <= req_now_ms;
         req_ff.row    <= req_cell_row;
         req_ff.col    <= req_cell_col;
         req_ff.chr    <= req_cell_char;
         idx_ff        <= idx_in;
      end
   end

   // decide step: result, state updates and write back
   always_comb begin
      logic start_ok;
      logic flush;
      logic hit;
      start_ok = share_en_ff && (req_ff.now_ms >= next_scan_ff);
      flush    = scan_active_ff && (pending_ff != '0);
      hit      = scan_active_ff && (idx_ff < IDX_W'(CELL_COUNT)) &&
                 (rd_data_ff != req_ff.chr);

      have_res       = 1'b0;
      res_kind       = KIND_END;
      res_row        = '0;
      res_col        = '0;
      res_char       = '0;
      res_recs       = pending_ff;
      rec_write      = 1'b0;
      start_clear    = 1'b0;
      scan_active_in = scan_active_ff;
      snap_valid_in  = snap_valid_ff;
      next_scan_in   = next_scan_ff;
      pending_in     = pending_ff;

      unique case (req_ff.cmd)
         CMD_SCAN_START: begin
            // flush what the previous scan left, then try to open a new one
            have_res       = flush;
            pending_in     = '0;
            scan_active_in = start_ok;
            if (start_ok) begin
               next_scan_in = req_ff.now_ms + 32'(interval_ff);
               if (!snap_valid_ff) begin
                  start_clear   = 1'b1;
                  snap_valid_in = 1'b1;
               end
            end
         end
         CMD_CELL: begin
            if (hit) begin
               have_res = 1'b1;
               if (pending_ff >= PEND_W'(RECORDS_PER_PACKET)) begin
                  // packet full: close it and abort the scan
                  scan_active_in = 1'b0;
                  pending_in     = '0;
               end else begin
                  res_kind   = KIND_RECORD;
                  res_row    = req_ff.row;
                  res_col    = req_ff.col;
                  res_char   = req_ff.chr;
                  res_recs   = '0;
                  rec_write  = 1'b1;
                  pending_in = pending_ff + 1'b1;
               end
            end
         end
         CMD_SCAN_END: begin
            have_res       = flush;
            scan_active_in = 1'b0;
            pending_in     = '0;
         end
         CMD_RESYNC: begin
            snap_valid_in = 1'b0;
         end
      endcase
   end

   // result register is busy only when full and not being drained
   assign stall  = (state_ff == ST_DECIDE) && have_res && rsp_valid_ff && !rsp_ready;
   assign commit = (state_ff == ST_DECIDE) && !stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!stall) state_in = start_clear ? ST_CLEAR : ST_IDLE;
         end
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = req_ff.chr;
      clr_addr_in = '0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_READ:   mem_rd_en = 1'b1;
         ST_DECIDE: mem_wr_en = commit && rec_write;
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      endcase
   end

   // snapshot memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         snapshot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= snapshot_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_active_ff <= 1'b0;
         snap_valid_ff  <= 1'b0;
         next_scan_ff   <= '0;
         pending_ff     <= '0;
         clr_addr_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         if (commit) begin
            scan_active_ff <= scan_active_in;
            snap_valid_ff  <= snap_valid_in;
            next_scan_ff   <= next_scan_in;
            pending_ff     <= pending_in;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit && have_res) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && have_res) begin
         rsp_kind_ff <= res_kind;
         rsp_row_ff  <= res_row;
         rsp_col_ff  <= res_col;
         rsp_char_ff <= res_char;
         rsp_recs_ff <= res_recs;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_col        = rsp_col_ff;
   assign rsp_out_char       = rsp_char_ff;
   assign rsp_packet_records = rsp_recs_ff;

endmodule

@@ rtl/scde_checker.sv @@
// ----------------------------------------------------------------------------
// scde_checker
// port-level checks for the screen cell diff encoder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scde_checker
   import scde_pkg::*;
#(
   parameter int RECORDS_PER_PACKET = RECORDS_PER_PACKET_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [7:0]        rsp_out_row,
   input logic [7:0]        rsp_out_col,
   input logic [7:0]        rsp_out_char,
   input logic [PEND_W-1:0] rsp_packet_records
);

   logic [PEND_W+24:0] rsp_pl;
   logic               rsp_wait;
   logic               req_taken;
   logic               end_seen;
   logic               end_ok;
   logic               rec_seen;
   logic               rec_ok;

   assign rsp_pl    = {rsp_kind, rsp_out_row, rsp_out_col, rsp_out_char, rsp_packet_records};
   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign req_taken = req_valid && req_ready;
   assign end_seen  = rsp_valid && (rsp_kind == KIND_END);
   assign rec_seen  = rsp_valid && (rsp_kind == KIND_RECORD);
   assign end_ok    = ({rsp_out_row, rsp_out_col, rsp_out_char} == 24'd0) &&
                      (rsp_packet_records != '0) &&
                      (rsp_packet_records <= PEND_W'(RECORDS_PER_PACKET));
   assign rec_ok    = (rsp_packet_records == '0);

   // a waiting result holds its payload
   `SCDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_pl), "rsp moved")

   // one request at a time: ready drops after every accept
   `SCDE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_taken, !req_ready, "accepted while busy")

   // packet end carries no cell and closes a nonempty packet
   `SCDE_ASSERT_IMPLY(a_end_fields, clock, reset, end_seen, end_ok, "bad packet end")

   // a change record has no packet count
   `SCDE_ASSERT_IMPLY(a_record_fields, clock, reset, rec_seen, rec_ok, "record with count")

endmodule

bind screen_cell_diff_encoder scde_checker #(
   .RECORDS_PER_PACKET(RECORDS_PER_PACKET)
) u_scde_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the terminal screen change encoder
// ----------------------------------------------------------------------------
// A table of hand-picked requests goes first. Some rows carry a hand-written
// response or its absence, and the others are checked against a cycle-free
// copy of the encoder kept in this module. After that come seven register
// settings, each with randomized scans (scan start, cells, usually a scan
// end) mixed with resyncs and stray requests. Both handshake sides stall at
// random, and once the response side holds off long enough to back the
// block up into its request port.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import scde_pkg::*;

   // slowest correct run: every request with its gap and stall, plus the
   // clearing passes and phase settles, well inside RUN_LIMIT
   localparam int RUN_LIMIT  = 1_000_000;
   localparam int SETTLE     = CELL_COUNT_DEF + 16;
   localparam int HOLD_LEN   = 400;
   localparam int NUM_PHASES = 7;
   localparam int SHADOW_AW  = $clog2(CELL_COUNT_DEF);

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_RSP,
      GIVEN_RSP
   } check_mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] chr;
      logic [5:0] cnt;
   } cell_rsp_type;

   typedef struct packed {
      cmd_type        cmd;
      logic [31:0]    now;
      logic [7:0]     row;
      logic [7:0]     col;
      logic [7:0]     chr;
      logic [4:0]     reps;
      check_mode_type mode;
      cell_rsp_type   rsp;
   } stim_row_type;

   typedef struct packed {
      logic         given;
      logic         has;
      cell_rsp_type rsp;
   } req_note_type;

   // hand-picked requests, run on reset register values
   localparam stim_row_type DIRECTED [27] = '{
      // cell and scan end outside any scan, resync before the first scan
      '{CMD_CELL,       32'h0000_0000, 8'd0,   8'd0,   8'h41, 5'd1,  NO_RSP, '0},
      '{CMD_SCAN_END,   32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_RESYNC,     32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      // first scan at time zero, snapshot gets cleared
      '{CMD_SCAN_START, 32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd0,   8'd0,   8'h41, 5'd1,  GIVEN_RSP,
        '{KIND_RECORD, 8'd0, 8'd0, 8'h41, 6'd0}},
      // unchanged cell
      '{CMD_CELL,       32'h0000_0000, 8'd0,   8'd0,   8'h41, 5'd1,  NO_RSP, '0},
      // far beyond the store
      '{CMD_CELL,       32'hFFFF_FFFF, 8'd255, 8'd255, 8'hFF, 5'd1,  NO_RSP, '0},
      // last entry of the store, then the first one past it
      '{CMD_CELL,       32'h0000_0000, 8'd25,  8'd47,  8'hFF, 5'd1,  GIVEN_RSP,
        '{KIND_RECORD, 8'd25, 8'd47, 8'hFF, 6'd0}},
      '{CMD_CELL,       32'h0000_0000, 8'd25,  8'd48,  8'hAA, 5'd1,  NO_RSP, '0},
      // change back to character zero
      '{CMD_CELL,       32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  GIVEN_RSP,
        '{KIND_RECORD, 8'd0, 8'd0, 8'h00, 6'd0}},
      // too early: rejected, pending records flushed
      '{CMD_SCAN_START, 32'h0000_0005, 8'd0,   8'd0,   8'h00, 5'd1,  GIVEN_RSP,
        '{KIND_END, 8'd0, 8'd0, 8'h00, 6'd3}},
      '{CMD_CELL,       32'h0000_0000, 8'd1,   8'd1,   8'h5A, 5'd1,  NO_RSP, '0},
      // latest time, next-scan time wraps around
      '{CMD_SCAN_START, 32'hFFFF_FFFF, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      // start inside an open scan with nothing pending
      '{CMD_SCAN_START, 32'h0000_000F, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd2,   8'd3,   8'h71, 5'd1,  GIVEN_RSP,
        '{KIND_RECORD, 8'd2, 8'd3, 8'h71, 6'd0}},
      // start inside an open scan with a record pending
      '{CMD_SCAN_START, 32'h0000_001F, 8'd0,   8'd0,   8'h00, 5'd1,  GIVEN_RSP,
        '{KIND_END, 8'd0, 8'd0, 8'h00, 6'd1}},
      // fill a packet, then one more change aborts the scan
      '{CMD_CELL,       32'h0000_0000, 8'd3,   8'd0,   8'h30, 5'd16, BY_MODEL, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd4,   8'd0,   8'h78, 5'd1,  GIVEN_RSP,
        '{KIND_END, 8'd0, 8'd0, 8'h00, 6'd16}},
      '{CMD_CELL,       32'h0000_0000, 8'd4,   8'd1,   8'h79, 5'd1,  NO_RSP, '0},
      // resync in the middle of a scan leaves the scan open
      '{CMD_SCAN_START, 32'h0000_0040, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd5,   8'd5,   8'h65, 5'd1,  GIVEN_RSP,
        '{KIND_RECORD, 8'd5, 8'd5, 8'h65, 6'd0}},
      '{CMD_RESYNC,     32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd5,   8'd6,   8'h66, 5'd1,  BY_MODEL, '0},
      '{CMD_SCAN_END,   32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  GIVEN_RSP,
        '{KIND_END, 8'd0, 8'd0, 8'h00, 6'd2}},
      // next scan clears the snapshot again
      '{CMD_SCAN_START, 32'h0000_0050, 8'd0,   8'd0,   8'h00, 5'd1,  NO_RSP, '0},
      '{CMD_CELL,       32'h0000_0000, 8'd5,   8'd5,   8'h65, 5'd1,  BY_MODEL, '0},
      '{CMD_SCAN_END,   32'h0000_0000, 8'd0,   8'd0,   8'h00, 5'd1,  BY_MODEL, '0}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_cmd;
   logic [31:0]       req_now_ms;
   logic [7:0]        req_cell_row;
   logic [7:0]        req_cell_col;
   logic [7:0]        req_cell_char;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_kind;
   logic [7:0]        rsp_out_row;
   logic [7:0]        rsp_out_col;
   logic [7:0]        rsp_out_char;
   logic [PEND_W-1:0] rsp_packet_records;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   // encoder copy: snapshot, scan state and register values
   logic [7:0]  shadow_chars [CELL_COUNT_DEF];
   logic        shadow_valid = 1'b0;
   logic [31:0] next_scan_ms = '0;
   logic        scanning     = 1'b0;
   int          open_count   = 0;
   logic        cfg_share    = SHARE_ENABLE_RST;
   logic [15:0] cfg_interval = SCAN_INTERVAL_RST;
   logic [7:0]  cfg_cols     = SCREEN_COLS_RST;

   cell_rsp_type awaited_rsps [$];   // responses still to come, oldest first
   req_note_type req_notes    [$];   // per request: hand-written response, if any

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  req_count   = 0;
   int  rec_count   = 0;
   int  end_count   = 0;
   int  scan_count  = 0;
   int  clear_count = 0;
   int  send_calm   = 0;
   int  recv_calm   = 0;
   bit  hold_rsp    = 1'b0;

   req_note_type mon_note;
   logic         mon_has;
   cell_rsp_type mon_pred;
   cell_rsp_type mon_exp;
   cell_rsp_type mon_act;

   screen_cell_diff_encoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_now_ms         (req_now_ms),
      .req_cell_row       (req_cell_row),
      .req_cell_col       (req_cell_col),
      .req_cell_char      (req_cell_char),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_out_char       (rsp_out_char),
      .rsp_packet_records (rsp_packet_records),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle cycles before the next handshake, with calm stretches of zero
   function automatic int pick_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 7);
   endfunction

   // packet-end marker for what the open packet holds
   function automatic cell_rsp_type close_packet();
      cell_rsp_type p;
      p      = '0;
      p.kind = KIND_END;
      p.cnt  = 6'(open_count);
      open_count = 0;
      return p;
   endfunction

   // response (if any) of the encoder to one accepted request
   task automatic predict_change(input cmd_type c, input logic [31:0] now,
                                 input logic [7:0] row, input logic [7:0] col,
                                 input logic [7:0] chr,
                                 output logic has, output cell_rsp_type r);
      int unsigned idx;
      has = 1'b0;
      r   = '0;
      case (c)
         CMD_SCAN_START: begin
            // flush what the previous scan left open
            if (scanning && open_count != 0) begin
               r   = close_packet();
               has = 1'b1;
            end
            scanning   = 1'b0;
            open_count = 0;
            if (cfg_share && now >= next_scan_ms) begin
               next_scan_ms = now + 32'(cfg_interval);   // wraps mod 2^32
               if (!shadow_valid) begin
                  foreach (shadow_chars[i]) shadow_chars[i] = 8'h00;
                  shadow_valid = 1'b1;
                  clear_count++;
               end
               scanning = 1'b1;
               scan_count++;
            end
         end
         CMD_CELL: begin
            if (scanning) begin
               idx = 32'(row) * 32'(cfg_cols) + 32'(col);
               if (idx < CELL_COUNT_DEF && shadow_chars[SHADOW_AW'(idx)] != chr) begin
                  if (open_count >= RECORDS_PER_PACKET_DEF) begin
                     // full packet: marker, cell dropped, scan aborted
                     scanning = 1'b0;
                     r        = close_packet();
                  end else begin
                     r.kind = KIND_RECORD;
                     r.row  = row;
                     r.col  = col;
                     r.chr  = chr;
                     shadow_chars[SHADOW_AW'(idx)] = chr;
                     open_count++;
                  end
                  has = 1'b1;
               end
            end
         end
         CMD_SCAN_END: begin
            if (scanning && open_count != 0) begin
               r   = close_packet();
               has = 1'b1;
            end
            scanning   = 1'b0;
            open_count = 0;
         end
         default: shadow_valid = 1'b0;   // resync
      endcase
   endtask

   function automatic bit same_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // monitor: register writes, accepted requests, accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHARE_ENABLE:   cfg_share    = csr_wdata[0];
               CSR_SCAN_INTERVAL:  cfg_interval = csr_wdata[15:0];
               CSR_SCREEN_COLUMNS: cfg_cols     = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_count++;
            mon_note = req_notes.pop_front();
            predict_change(cmd_type'(req_cmd), req_now_ms, req_cell_row, req_cell_col,
                           req_cell_char, mon_has, mon_pred);
            // hand-written rows override the copy's answer
            if (mon_note.given) begin
               mon_has  = mon_note.has;
               mon_pred = mon_note.rsp;
            end
            if (mon_has) awaited_rsps.push_back(mon_pred);
         end
         if (rsp_valid && rsp_ready) begin
            mon_act = '{rsp_kind, rsp_out_row, rsp_out_col, rsp_out_char, rsp_packet_records};
            if (mon_act.kind == KIND_END) end_count++;
            else rec_count++;
            if (awaited_rsps.size() == 0) begin
               $error("response with none awaited: kind %0d row %0d col %0d",
                      mon_act.kind, mon_act.row, mon_act.col);
               fail_count++;
            end else begin
               mon_exp = awaited_rsps.pop_front();
               if (!(same_field("kind", int'(mon_exp.kind), int'(mon_act.kind))
                     & same_field("out_row", int'(mon_exp.row), int'(mon_act.row))
                     & same_field("out_col", int'(mon_exp.col), int'(mon_act.col))
                     & same_field("out_char", int'(mon_exp.chr), int'(mon_act.chr))
                     & same_field("packet_records", int'(mon_exp.cnt),
                                  int'(mon_act.cnt))))
                  fail_count++;
            end
         end
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            // long hold-off so the block backs up into its request port
            rsp_ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            held = 1'b1;
         end
         stall = pick_idle(recv_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // run guard
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run limit of %0d cycles reached", RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // offer one request after a random gap, return at its acceptance edge
   task automatic send_req(input cmd_type c, input logic [31:0] now,
                           input logic [7:0] row, input logic [7:0] col,
                           input logic [7:0] chr, input req_note_type note);
      int gap;
      gap = pick_idle(send_calm);
      req_notes.push_back(note);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= c;
      req_now_ms    <= now;
      req_cell_row  <= row;
      req_cell_col  <= col;
      req_cell_char <= chr;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   // drain all responses, then wait out a possible clearing pass
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int           i;
      int           k;
      int           p;
      int           n;
      int           sent;
      int           cols;
      int           interval;
      int           row_top;
      logic [7:0]   row;
      logic [7:0]   col;
      logic [7:0]   chr;
      logic [31:0]  scan_clock_ms;
      req_note_type note;
      stim_row_type d;
      int           ph_share    [NUM_PHASES];
      int           ph_interval [NUM_PHASES];
      int           ph_cols     [NUM_PHASES];
      int           ph_items    [NUM_PHASES];

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_SCAN_START;
      req_now_ms    <= '0;
      req_cell_row  <= '0;
      req_cell_col  <= '0;
      req_cell_char <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_SHARE_ENABLE;
      csr_wdata     <= '0;

      // settings: defaults, extremes, sharing off, zero columns, random
      ph_share    = '{1, 1, 1,     0,  1, 1, 1};
      ph_interval = '{16, 0, 65535, 16, 3, 0, 0};
      ph_cols     = '{80, 255, 1,   80, 0, 0, 0};
      ph_items    = '{150, 150, 150, 40, 150, 130, 130};
      ph_interval[5] = $urandom_range(0, 300);
      ph_cols[5]     = $urandom_range(1, 255);
      ph_interval[6] = $urandom_range(0, 65535);
      ph_cols[6]     = $urandom_range(0, 255);
      // scan times live in the upper half, stray times in the lower
      scan_clock_ms = 32'h8000_0000 | ($urandom & 32'h3FFF_FFFF);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table on reset register values
      for (i = 0; i < $size(DIRECTED); i++) begin
         d          = DIRECTED[i];
         note.given = (d.mode != BY_MODEL);
         note.has   = (d.mode == GIVEN_RSP);
         note.rsp   = d.rsp;
         for (k = 0; k < int'(d.reps); k++)
            send_req(d.cmd, d.now, d.row, d.col + 8'(k), d.chr + 8'(k), note);
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_csr(CSR_SHARE_ENABLE,   CSR_W'(ph_share[p]));
         write_csr(CSR_SCAN_INTERVAL,  CSR_W'(ph_interval[p]));
         write_csr(CSR_SCREEN_COLUMNS, CSR_W'(ph_cols[p]));
         csr_valid <= 1'b0;
         cols     = ph_cols[p];
         interval = ph_interval[p];
         row_top  = (cols == 0) ? 255 : ((2047 / cols > 255) ? 255 : 2047 / cols);
         if (p == 1) hold_rsp = 1'b1;
         note = '0;
         sent = 0;
         while (sent < ph_items[p]) begin
            k = $urandom_range(0, 99);
            if (k < 5) begin
               // resync, forces a clearing pass on the next open
               send_req(CMD_RESYNC, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                        note);
               sent++;
            end else if (k < 13) begin
               // stray request: any command, early time, any cell
               send_req(cmd_type'($urandom_range(0, 3)), $urandom & 32'h7FFF_FFFF,
                        8'($urandom), 8'($urandom), 8'($urandom), note);
               sent++;
            end else begin
               // a scan: start, a run of cells, usually an end
               if ($urandom_range(0, 4) != 0)
                  scan_clock_ms += 32'(interval) + $urandom_range(0, 8);
               else
                  scan_clock_ms += $urandom_range(0, interval);
               send_req(CMD_SCAN_START, scan_clock_ms, 8'($urandom), 8'($urandom),
                        8'($urandom), note);
               sent++;
               n = $urandom_range(0, 24);
               repeat (n) begin
                  k = $urandom_range(0, 99);
                  if (k < 40) begin
                     // small hot area, so unchanged cells come up often
                     row = 8'($urandom_range(0, 3));
                     col = 8'($urandom_range(0, 7));
                  end else if (k < 85) begin
                     row = 8'($urandom_range(0, row_top));
                     col = (cols == 0) ? 8'($urandom) : 8'($urandom_range(0, cols - 1));
                  end else begin
                     row = 8'($urandom);
                     col = 8'($urandom);
                  end
                  case ($urandom_range(0, 3))
                     0:       chr = 8'h00;
                     1:       chr = 8'h20;
                     2:       chr = 8'h41;
                     default: chr = 8'($urandom);
                  endcase
                  send_req(CMD_CELL, $urandom, row, col, chr, note);
                  sent++;
               end
               if ($urandom_range(0, 99) < 85) begin
                  send_req(CMD_SCAN_END, $urandom, 8'($urandom), 8'($urandom),
                           8'($urandom), note);
                  sent++;
               end
            end
         end
      end

      settle();
      $display("%0d requests over %0d register settings, %0d scans opened, %0d clears",
               req_count, NUM_PHASES + 1, scan_count, clear_count);
      $display("%0d change records and %0d packet-end markers checked",
               rec_count, end_count);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/scde_pkg.sv
rtl/screen_cell_diff_encoder.sv
rtl/scde_checker.sv
test/testbench.sv
